// ----- design/bsort_pkg.sv -----
// ----------------------------------------------------------------------------
// bsort_pkg
// shared widths and defaults for the descending bubble sort engine
// ----------------------------------------------------------------------------
package bsort_pkg;

    localparam int DATA_W           = 32;
    localparam int DEFAULT_CAPACITY = 64;

endpackage

// ----- design/bsort_mem.sv -----
// ----------------------------------------------------------------------------
// bsort_mem
// element store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module bsort_mem
    import bsort_pkg::*;
#(
    parameter int DEPTH = DEFAULT_CAPACITY,
    parameter int AW    = $clog2(DEFAULT_CAPACITY)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_array [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem_array[raddr];
    end

endmodule

// ----- design/bsort_cmp.sv -----
// ----------------------------------------------------------------------------
// bsort_cmp
// compare and swap step of one bubble pass
// ----------------------------------------------------------------------------
module bsort_cmp
    import bsort_pkg::*;
(
    input  logic [DATA_W-1:0] hold,
    input  logic [DATA_W-1:0] fetched,
    output logic [DATA_W-1:0] write_value,
    output logic [DATA_W-1:0] hold_next,
    output logic              swap
);

    // the earlier element moves on only while it is strictly smaller
    assign swap        = $signed(hold) < $signed(fetched);
    assign write_value = swap ? fetched : hold;
    assign hold_next   = swap ? hold : fetched;

endmodule

// ----- design/descending_bubble_sort_engine_unit.sv -----
// ----------------------------------------------------------------------------
// descending_bubble_sort_engine_unit
// collects a set of signed values, bubble sorts it descending in a ram and
// streams it back out
// ----------------------------------------------------------------------------
//  channel | dir | tdata            | tlast          | tuser
//  s_*     | in  | sample_value[31:0] | is_final     | -
//  m_*     | out | sorted_value[31:0] | is_end       | overflowed
//
//  loading takes one cycle per input beat
//  sorting works through the ram one element per cycle; a pass of length m
//  runs S_FIRST, S_CMP up to index m, then S_LAST; m then drops by one
//  each output beat: ram read, then output register held until m_tready
//  input is not taken while a set is sorting or being emitted
//  reset clears count, drop flag and control; the ram needs no clearing
// ----------------------------------------------------------------------------
module descending_bubble_sort_engine_unit
    import bsort_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] sample_value
    input  logic              s_tlast,

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic              m_tlast,
    output logic [0:0]        m_tuser    // [0] overflowed
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_FIRST,
        S_CMP,
        S_LAST,
        S_OSTART,
        S_OREAD,
        S_OSHOW
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     count_reg;
    logic              drop_reg;
    logic [AW-1:0]     k_reg;
    logic [AW-1:0]     m_reg;
    logic [AW-1:0]     idx_reg;
    logic [DATA_W-1:0] hold_reg;
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;
    logic              m_tuser_reg;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic [DATA_W-1:0] cmp_wvalue;
    logic [DATA_W-1:0] cmp_hold_next;
    logic              cmp_swap;

    logic              in_beat;
    logic              store_room;
    logic [CW-1:0]     count_after;
    logic [AW-1:0]     last_idx;

    assign in_beat     = s_tvalid && s_tready;
    assign store_room  = count_reg < CW'(CAPACITY);
    assign count_after = store_room ? count_reg + 1'b1 : count_reg;
    assign last_idx    = AW'(count_reg - 1'b1);

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    bsort_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bsort_cmp u_cmp (
        .hold        (hold_reg),
        .fetched     (mem_rdata),
        .write_value (cmp_wvalue),
        .hold_next   (cmp_hold_next),
        .swap        (cmp_swap)
    );

    // ram port steering
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = s_tdata;
        mem_raddr = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                mem_we    = in_beat && store_room;
                mem_waddr = AW'(count_reg);
            end
            S_FIRST:
            begin
                mem_raddr = AW'(1);
            end
            S_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = k_reg - 1'b1;
                mem_wdata = cmp_wvalue;
                mem_raddr = k_reg + 1'b1;
            end
            S_LAST:
            begin
                mem_we    = 1'b1;
                mem_waddr = m_reg;
                mem_wdata = hold_reg;
            end
            S_OSTART:
            begin
                mem_raddr = '0;
            end
            S_OREAD:
            begin
                mem_raddr = idx_reg;
            end
            S_OSHOW:
            begin
                mem_raddr = idx_reg + 1'b1;
            end
            default:
            begin
                mem_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            drop_reg     <= 1'b0;
            k_reg        <= '0;
            m_reg        <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_beat)
                    begin
                        count_reg <= count_after;
                        if (!store_room)
                        begin
                            drop_reg <= 1'b1;
                        end
                        if (s_tlast)
                        begin
                            m_reg <= AW'(count_after - 1'b1);
                            if (count_after > CW'(1))
                            begin
                                state_reg <= S_FIRST;
                            end
                            else
                            begin
                                state_reg <= S_OSTART;
                            end
                        end
                    end
                end
                S_FIRST:
                begin
                    k_reg     <= AW'(1);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (k_reg == m_reg)
                    begin
                        state_reg <= S_LAST;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_LAST:
                begin
                    if (m_reg == AW'(1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_OREAD;
                    end
                    else
                    begin
                        m_reg     <= m_reg - 1'b1;
                        state_reg <= S_FIRST;
                    end
                end
                S_OSTART:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_OREAD;
                end
                S_OREAD:
                begin
                    m_tvalid_reg <= 1'b1;
                    m_tlast_reg  <= (idx_reg == last_idx);
                    m_tuser_reg  <= drop_reg;
                    state_reg    <= S_OSHOW;
                end
                S_OSHOW:
                begin
                    if (m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                        if (m_tlast_reg)
                        begin
                            count_reg <= '0;
                            drop_reg  <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_OREAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // payload registers: bubbling element and output data
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIRST)
        begin
            hold_reg <= mem_rdata;
        end
        else if (state_reg == S_CMP)
        begin
            hold_reg <= cmp_hold_next;
        end
        if (state_reg == S_OREAD)
        begin
            m_tdata_reg <= mem_rdata;
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input taken while output beat pending");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count beyond capacity");

    a_pass_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (k_reg != '0 && k_reg <= m_reg))
        else $error("compare index outside pass");

    a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (count_reg == '0 && !drop_reg))
        else $error("set state not cleared after final beat");

    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP && cmp_swap) |->
            ($signed(cmp_wvalue) > $signed(cmp_hold_next)))
        else $error("swap did not put larger element first");
`endif

endmodule

// ----- test/tb_descending_bubble_sort_engine_unit.sv -----
// ----------------------------------------------------------------------------
// tb_descending_bubble_sort_engine_unit
// streams sets of signed samples into the sort engine and checks every sorted
// beat against a behavioral descending bubble sort, including store overflow,
// with random gaps on the input and random backpressure on the output
// ----------------------------------------------------------------------------
module tb_descending_bubble_sort_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bsort_pkg::*;

    localparam int CAP          = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 420;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ERR_SHOWN    = 10;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              is_end;
        logic              ovf;
    } sorted_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last_beat;
        logic              typed;     // single-sample set, result written below
        logic [DATA_W-1:0] want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic [0:0]        m_tuser;

    sorted_beat_t             sorted_q[$];
    logic signed [DATA_W-1:0] set_store [0:CAP-1];
    int                       set_count;
    logic                     set_dropped;
    int                       errors;
    int                       cycle_count;
    bit                       no_idle;

    stim_row_t stim_rows [0:22] = '{
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
        '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
        // mixed set with both extremes and a repeated value
        '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0005, 1'b1, 1'b0, 32'h0},
        // all equal
        '{32'h0000_0007, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0007, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0007, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0007, 1'b1, 1'b0, 32'h0},
        // already descending
        '{32'd100,       1'b0, 1'b0, 32'h0},
        '{32'd50,        1'b0, 1'b0, 32'h0},
        '{-32'sd50,      1'b0, 1'b0, 32'h0},
        '{-32'sd100,     1'b1, 1'b0, 32'h0},
        // ascending, worst case for swaps
        '{-32'sd100,     1'b0, 1'b0, 32'h0},
        '{-32'sd50,      1'b0, 1'b0, 32'h0},
        '{32'd50,        1'b0, 1'b0, 32'h0},
        '{32'd100,       1'b1, 1'b0, 32'h0},
        '{32'h5555_5555, 1'b0, 1'b0, 32'h0},
        '{32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0}
    };

    descending_bubble_sort_engine_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // store the accepted sample; on the last beat sort the set and queue it
    task automatic record_sample(input logic [DATA_W-1:0] v, input logic last_beat,
                                 input logic typed, input logic [DATA_W-1:0] want);
        logic signed [DATA_W-1:0] tmp;
        int                       n;
        if (set_count < CAP)
        begin
            set_store[set_count] = v;
            set_count++;
        end
        else
        begin
            set_dropped = 1'b1;
        end
        if (last_beat)
        begin
            n = set_count;
            for (int p = 0; p < n - 1; p++)
            begin
                for (int k = 0; k < n - 1 - p; k++)
                begin
                    // strict compare keeps equal values in arrival order
                    if (set_store[k] < set_store[k + 1])
                    begin
                        tmp              = set_store[k];
                        set_store[k]     = set_store[k + 1];
                        set_store[k + 1] = tmp;
                    end
                end
            end
            if (typed)
            begin
                sorted_q.push_back('{want, 1'b1, 1'b0});
            end
            else
            begin
                for (int k = 0; k < n; k++)
                    sorted_q.push_back('{set_store[k], logic'(k == n - 1), set_dropped});
            end
            set_count   = 0;
            set_dropped = 1'b0;
        end
    endtask

    task automatic send_sample(input logic [DATA_W-1:0] v, input logic last_beat);
        int gap;
        if (!no_idle && $urandom_range(99) < 30)
        begin
            gap = $urandom_range(3, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last_beat;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // hold the input off until every queued beat has come out
    task automatic drain_sorted();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sorted_q.size() != 0);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom;
        else if (r < 85)
            return DATA_W'(int'($urandom_range(16)) - 8);   // dense duplicates
        else
        begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
    endfunction

    function automatic int pick_set_len(input int set_idx);
        int r;
        if (set_idx == 0)
            return CAP;          // exactly full
        if (set_idx == 1)
            return CAP + 1;      // last beat dropped
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(8, 1);
        else if (r < 93)
            return $urandom_range(30, 9);
        else
            return $urandom_range(CAP + 6, CAP - 4);
    endfunction

    always @(posedge clk)
    begin : sink
        sorted_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sorted_q.size() == 0)
            begin
                errors++;
                if (errors <= ERR_SHOWN)
                    $display("unexpected beat: value=%h last=%b ovf=%b",
                             m_tdata, m_tlast, m_tuser[0]);
            end
            else
            begin
                want = sorted_q.pop_front();
                if (m_tdata !== want.value || m_tlast !== want.is_end ||
                    m_tuser[0] !== want.ovf)
                begin
                    errors++;
                    if (errors <= ERR_SHOWN)
                        $display("mismatch: exp value=%h last=%b ovf=%b, got value=%h last=%b ovf=%b",
                                 want.value, want.is_end, want.ovf,
                                 m_tdata, m_tlast, m_tuser[0]);
                end
            end
        end
        m_tready <= no_idle || ($urandom_range(99) >= 30);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int                sent;
        int                set_idx;
        int                set_len;
        logic [DATA_W-1:0] v;
        logic              last_beat;
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        set_count   = 0;
        set_dropped = 1'b0;
        errors      = 0;
        cycle_count = 0;
        no_idle     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            send_sample(stim_rows[i].value, stim_rows[i].last_beat);
            record_sample(stim_rows[i].value, stim_rows[i].last_beat,
                          stim_rows[i].typed, stim_rows[i].want);
        end
        drain_sorted();

        sent    = 0;
        set_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_len = pick_set_len(set_idx);
            for (int k = 0; k < set_len; k++)
            begin
                no_idle   = (sent >= 150 && sent < 260);
                v         = pick_value();
                last_beat = (k == set_len - 1);
                send_sample(v, last_beat);
                record_sample(v, last_beat, 1'b0, '0);
                sent++;
            end
            set_idx++;
            if (set_idx == 6)
                drain_sorted();
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        while (sorted_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
